/* rtl/ppdc_pkg.sv */
// ----------------------------------------------------------------------------
// ppdc_pkg: shared types and constants of the pure pursuit drive command unit
// Fixed point widths, CORDIC angle table, register indexes and cell payloads.
// ----------------------------------------------------------------------------
package ppdc_pkg;

    // CORDIC vector and angle widths (2^-16 rad angles)
    localparam int CW = 31;
    localparam int ZW = 20;
    // body frame coordinate width, 1/4096 m
    localparam int LW = 18;
    // square root operand width and result width
    localparam int SW = 36;
    localparam int RW = 18;
    // divider numerator, quotient and shifted divisor widths
    localparam int NW = 43;
    localparam int QW = 18;
    localparam int DW = SW + QW;

    localparam int ROT_STEPS  = 16;
    localparam int SQRT_STEPS = SW / 2;

    localparam logic signed [ZW-1:0] EIGHTH    = 20'sd51472;
    localparam logic signed [ZW-1:0] QUARTER   = 20'sd102944;
    localparam logic signed [ZW-1:0] HALF_TURN = 20'sd205887;
    localparam logic signed [16:0]   PI_OUT    = 17'sd25736;
    localparam logic signed [16:0]   CORDIC_K  = 17'sd39797;
    localparam logic [RW-1:0]        LOOK_FLOOR = 18'd205;
    localparam logic signed [LW-1:0] AHEAD_MIN  = 18'sd82;
    localparam logic [12:0]          YAW_CEIL   = 13'd4096;

    localparam logic signed [ZW-1:0] ATAN_TAB [ROT_STEPS] = '{
        20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150,
        20'sd4091,  20'sd2047,  20'sd1024,  20'sd512,
        20'sd256,   20'sd128,   20'sd64,    20'sd32,
        20'sd16,    20'sd8,     20'sd4,     20'sd2
    };

    // configuration register indexes
    localparam logic [2:0] REG_MAX_FWD   = 3'd0;
    localparam logic [2:0] REG_PURSUIT   = 3'd1;
    localparam logic [2:0] REG_MIN_SPEED = 3'd2;
    localparam logic [2:0] REG_YAW_GAIN  = 3'd3;
    localparam logic [2:0] REG_LAT_DB    = 3'd4;
    localparam logic [2:0] REG_CURV_DB   = 3'd5;
    localparam logic [2:0] REG_MAX_YAW   = 3'd6;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic [SW-1:0] v;
        logic [SW-1:0] r;
    } sqrt_t;

    typedef struct packed {
        logic [NW-1:0] rem;
        logic [SW-1:0] d;
        logic [QW-1:0] q;
    } div_t;

endpackage

/* rtl/ppdc_cordic_cell.sv */
// ----------------------------------------------------------------------------
// ppdc_cordic_cell: one CORDIC micro-rotation step
// Rotation mode steers by the residual angle, vectoring mode by the sign of y.
// ----------------------------------------------------------------------------
module ppdc_cordic_cell
    import ppdc_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  logic       vec,
    input  logic [3:0] step,
    input  cordic_t    din,
    output cordic_t    dout
);

    cordic_t dout_reg;
    cordic_t dout_next;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic ccw;

    always_comb
    begin
        xs  = din.x >>> step;
        ys  = din.y >>> step;
        ccw = vec ? !(din.y > 0) : (din.z >= 0);
        if (ccw)
        begin
            dout_next.x = din.x - ys;
            dout_next.y = din.y + xs;
            dout_next.z = din.z - ATAN_TAB[step];
        end
        else
        begin
            dout_next.x = din.x + ys;
            dout_next.y = din.y - xs;
            dout_next.z = din.z + ATAN_TAB[step];
        end
    end

    // advance with the chain
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

/* rtl/ppdc_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// ppdc_sqrt_cell: one digit of a restoring integer square root
// Resolves one result bit per cell, trial bit given by its position.
// ----------------------------------------------------------------------------
module ppdc_sqrt_cell
    import ppdc_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  logic [5:0] pos,
    input  sqrt_t      din,
    output sqrt_t      dout
);

    sqrt_t dout_reg;
    sqrt_t dout_next;
    logic [SW-1:0] bitv;
    logic [SW-1:0] trial;

    always_comb
    begin
        bitv  = SW'(1) << pos;
        trial = din.r + bitv;
        if (din.v >= trial)
        begin
            dout_next.v = din.v - trial;
            dout_next.r = (din.r >> 1) + bitv;
        end
        else
        begin
            dout_next.v = din.v;
            dout_next.r = din.r >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

/* rtl/ppdc_div_cell.sv */
// ----------------------------------------------------------------------------
// ppdc_div_cell: one quotient bit of a restoring divider
// Subtracts the divisor shifted to this cell's bit when it fits.
// ----------------------------------------------------------------------------
module ppdc_div_cell
    import ppdc_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  logic [4:0] pos,
    input  div_t       din,
    output div_t       dout
);

    div_t dout_reg;
    div_t dout_next;
    logic [DW-1:0] dd;

    always_comb
    begin
        dd        = DW'(din.d) << pos;
        dout_next = din;
        if (DW'(din.rem) >= dd)
        begin
            dout_next.rem = din.rem - dd[NW-1:0];
            dout_next.q   = din.q | (QW'(1) << pos);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

/* rtl/pure_pursuit_drive_command_unit.sv */
// ----------------------------------------------------------------------------
// pure_pursuit_drive_command_unit: pure pursuit forward speed and yaw command
// Turns a world-frame target offset and heading into a body-frame drive word.
// ----------------------------------------------------------------------------
// One input word is taken per clock unless the output stalls, and every word
// yields exactly one result word. The cell chain has 61 register stages:
// a quarter-turn reduction stage, 16 rotation CORDIC cells that bring the
// target into the body frame, a gain-correction multiply and round, the
// squares and their sum, 18 square-root cells for the lookahead length, the
// squaring of the lookahead and the divider set-up, 18 divider cells for the
// curvature 2y/L^2, a speed-times-curvature multiply and the output register.
// The in-place turn angle runs beside it through 16 vectoring CORDIC cells and
// a short shift line that lines it up with the drive path. The whole chain
// holds while a result word waits on the output; s_axis_tready then drops.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata and must only
// change while no word is in flight. Units: 1/4096 m, 1/4096 m/s and
// 1/8192 rad on the inputs.
// ----------------------------------------------------------------------------
module pure_pursuit_drive_command_unit
    import ppdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // target_dx[15:0], target_dy[31:16], heading[47:32], end_dist[63:48]
    input  logic [63:0] s_axis_tdata,
    // end_flag[0]
    input  logic        s_axis_tuser,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // forward_speed[13:0], yaw_cmd[27:14], zero fill [31:28]
    output logic [31:0] m_axis_tdata,
    // turning_in_place[0]
    output logic        m_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [13:0] cfg_wdata
);

    localparam int FRONT = 18;   // stages before the body frame coordinates
    localparam int SIDE  = 42;   // stages from body frame to output
    localparam int LAST  = FRONT + SIDE;
    localparam int TDLY  = 22;   // turn command alignment taps

    typedef struct packed {
        logic        is_end;
        logic [15:0] end_dist;
    } front_t;

    typedef struct packed {
        logic              is_end;
        logic [15:0]       end_dist;
        logic signed [LW-1:0] ly;
        logic              lx_neg;
        logic              ly_zero;
        logic              ahead;
    } side_t;

    function automatic logic signed [47:0] rsh(input logic signed [47:0] v,
                                               input int unsigned s);
        logic signed [47:0] half;
        half = 48'sd1 <<< (s - 1);
        if (v >= 0)
            return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    // ---------------- configuration registers ----------------
    logic [13:0] max_forward_speed_reg;
    logic [13:0] pursuit_speed_reg;
    logic [13:0] min_speed_reg;
    logic [11:0] yaw_gain_reg;
    logic [11:0] lateral_deadband_reg;
    logic [11:0] curvature_deadband_reg;
    logic [12:0] max_yaw_rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_forward_speed_reg  <= 14'd3072;
            pursuit_speed_reg      <= 14'd819;
            min_speed_reg          <= 14'd328;
            yaw_gain_reg           <= 12'd384;
            lateral_deadband_reg   <= 12'd164;
            curvature_deadband_reg <= 12'd164;
            max_yaw_rate_reg       <= 13'd4096;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_MAX_FWD:   max_forward_speed_reg  <= cfg_wdata;
                REG_PURSUIT:   pursuit_speed_reg      <= cfg_wdata;
                REG_MIN_SPEED: min_speed_reg          <= cfg_wdata;
                REG_YAW_GAIN:  yaw_gain_reg           <= cfg_wdata[11:0];
                REG_LAT_DB:    lateral_deadband_reg   <= cfg_wdata[11:0];
                REG_CURV_DB:   curvature_deadband_reg <= cfg_wdata[11:0];
                REG_MAX_YAW:   max_yaw_rate_reg       <= cfg_wdata[12:0];
                default:       ; // writes past the register list are dropped
            endcase
        end
    end

    // ---------------- chain control ----------------
    // Every stage moves together; hold everything while the output word waits.
    logic adv;
    logic [LAST:0] vld_reg;

    assign adv           = !vld_reg[LAST] || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAST-1:0], s_axis_tvalid};
        end
    end

    // ---------------- quarter-turn reduction ----------------
    logic signed [15:0]   in_dx;
    logic signed [15:0]   in_dy;
    logic signed [15:0]   in_hd;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic signed [ZW-1:0] z0;
    logic signed [ZW-1:0] zoff;
    logic [1:0]           quarters;
    cordic_t              rot0_next;
    front_t               front_reg [FRONT];

    assign in_dx = s_axis_tdata[15:0];
    assign in_dy = s_axis_tdata[31:16];
    assign in_hd = s_axis_tdata[47:32];

    always_comb
    begin
        x0 = CW'(in_dx) <<< 12;
        y0 = CW'(in_dy) <<< 12;
        z0 = -(ZW'(in_hd) <<< 3);
        // take out whole quarter turns until the angle sits within an eighth
        priority if (z0 > EIGHTH + 2 * QUARTER)
        begin
            quarters = 2'd3;
            zoff     = ZW'(3 * QUARTER);
        end
        else if (z0 > EIGHTH + QUARTER)
        begin
            quarters = 2'd2;
            zoff     = ZW'(2 * QUARTER);
        end
        else if (z0 > EIGHTH)
        begin
            quarters = 2'd1;
            zoff     = QUARTER;
        end
        else if (z0 < -EIGHTH - 2 * QUARTER)
        begin
            quarters = 2'd1;
            zoff     = ZW'(-3 * QUARTER);
        end
        else if (z0 < -EIGHTH - QUARTER)
        begin
            quarters = 2'd2;
            zoff     = ZW'(-2 * QUARTER);
        end
        else if (z0 < -EIGHTH)
        begin
            quarters = 2'd3;
            zoff     = -QUARTER;
        end
        else
        begin
            quarters = 2'd0;
            zoff     = '0;
        end
        rot0_next.z = z0 - zoff;
        unique case (quarters)
            2'd0:
            begin
                rot0_next.x = x0;
                rot0_next.y = y0;
            end
            2'd1:
            begin
                rot0_next.x = -y0;
                rot0_next.y = x0;
            end
            2'd2:
            begin
                rot0_next.x = -x0;
                rot0_next.y = -y0;
            end
            default:
            begin
                rot0_next.x = y0;
                rot0_next.y = -x0;
            end
        endcase
    end

    cordic_t rot_c [ROT_STEPS+1];
    cordic_t rot0_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rot0_reg <= rot0_next;
            front_reg[0].is_end   <= s_axis_tuser;
            front_reg[0].end_dist <= s_axis_tdata[63:48];
            for (int i = 1; i < FRONT; i++)
            begin
                front_reg[i] <= front_reg[i-1];
            end
        end
    end

    assign rot_c[0] = rot0_reg;

    // ---------------- rotation CORDIC chain ----------------
    for (genvar k = 0; k < ROT_STEPS; k++)
    begin : g_rot
        ppdc_cordic_cell u_cell (
            .clk  (clk),
            .en   (adv),
            .vec  (1'b0),
            .step (4'(k)),
            .din  (rot_c[k]),
            .dout (rot_c[k+1])
        );
    end

    // ---------------- gain correction and body frame ----------------
    logic signed [47:0]   px_reg;
    logic signed [47:0]   py_reg;
    logic signed [LW-1:0] lx_new;
    logic signed [LW-1:0] ly_new;
    logic signed [LW-1:0] lx_reg;
    side_t                side_reg [SIDE];

    assign lx_new = LW'(rsh(px_reg, 28));
    assign ly_new = LW'(rsh(py_reg, 28));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg <= 48'(rot_c[ROT_STEPS].x) * 48'(CORDIC_K);
            py_reg <= 48'(rot_c[ROT_STEPS].y) * 48'(CORDIC_K);
            lx_reg <= lx_new;
            side_reg[0].is_end   <= front_reg[FRONT-1].is_end;
            side_reg[0].end_dist <= front_reg[FRONT-1].end_dist;
            side_reg[0].ly       <= ly_new;
            side_reg[0].lx_neg   <= lx_new < 0;
            side_reg[0].ly_zero  <= ly_new == 0;
            side_reg[0].ahead    <= lx_new >= AHEAD_MIN;
            for (int i = 1; i < SIDE; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // ---------------- lookahead length: squares and root cells ----------------
    logic [SW-1:0] sqx_reg;
    logic [SW-1:0] sqy_reg;
    sqrt_t         sq_c [SQRT_STEPS+1];
    sqrt_t         sq0_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx_reg   <= SW'(lx_reg * lx_reg);
            sqy_reg   <= SW'(side_reg[0].ly * side_reg[0].ly);
            sq0_reg.v <= sqx_reg + sqy_reg;
            sq0_reg.r <= '0;
        end
    end

    assign sq_c[0] = sq0_reg;

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        ppdc_sqrt_cell u_cell (
            .clk  (clk),
            .en   (adv),
            .pos  (6'(SW - 2 - 2 * j)),
            .din  (sq_c[j]),
            .dout (sq_c[j+1])
        );
    end

    // ---------------- curvature divider ----------------
    logic [RW-1:0]  look;
    logic [SW-1:0]  lsq_reg;
    logic [LW-1:0]  ly_abs;
    logic           lat_zero;
    div_t           dv_c [QW+1];
    div_t           dv0_reg;

    assign look     = (sq_c[SQRT_STEPS].r[RW-1:0] < LOOK_FLOOR) ? LOOK_FLOOR
                                                                : sq_c[SQRT_STEPS].r[RW-1:0];
    assign ly_abs   = side_reg[21].ly[LW-1] ? LW'(-side_reg[21].ly) : LW'(side_reg[21].ly);
    // drop small lateral offsets before they bend the path
    assign lat_zero = ly_abs < LW'(lateral_deadband_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lsq_reg     <= SW'(look) * SW'(look);
            dv0_reg.rem <= (lat_zero ? NW'(0) : (NW'(ly_abs) << 25)) + NW'(lsq_reg >> 1);
            dv0_reg.d   <= lsq_reg;
            dv0_reg.q   <= '0;
        end
    end

    assign dv_c[0] = dv0_reg;

    for (genvar p = 0; p < QW; p++)
    begin : g_div
        ppdc_div_cell u_cell (
            .clk  (clk),
            .en   (adv),
            .pos  (5'(QW - 1 - p)),
            .din  (dv_c[p]),
            .dout (dv_c[p+1])
        );
    end

    // ---------------- in-place turn angle ----------------
    cordic_t            at_c [ROT_STEPS+1];
    cordic_t            at0_reg;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [16:0] ang_reg;
    logic signed [29:0] turn_prod_reg;
    logic signed [29:0] turn_dly_reg [TDLY];

    assign ax = CW'(lx_reg) <<< 12;
    assign ay = CW'(side_reg[0].ly) <<< 12;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // fold a target behind the robot into the right half plane
            if (ax < 0)
            begin
                at0_reg.x <= -ax;
                at0_reg.y <= -ay;
                at0_reg.z <= (ay >= 0) ? HALF_TURN : -HALF_TURN;
            end
            else
            begin
                at0_reg.x <= ax;
                at0_reg.y <= ay;
                at0_reg.z <= '0;
            end
            if (side_reg[17].ly_zero)
            begin
                ang_reg <= side_reg[17].lx_neg ? PI_OUT : 17'sd0;
            end
            else
            begin
                ang_reg <= 17'(rsh(48'(at_c[ROT_STEPS].z), 3));
            end
            turn_prod_reg   <= 30'($signed({1'b0, yaw_gain_reg})) * 30'(ang_reg);
            turn_dly_reg[0] <= turn_prod_reg;
            for (int i = 1; i < TDLY; i++)
            begin
                turn_dly_reg[i] <= turn_dly_reg[i-1];
            end
        end
    end

    assign at_c[0] = at0_reg;

    for (genvar k = 0; k < ROT_STEPS; k++)
    begin : g_atan
        ppdc_cordic_cell u_cell (
            .clk  (clk),
            .en   (adv),
            .vec  (1'b1),
            .step (4'(k)),
            .din  (at_c[k]),
            .dout (at_c[k+1])
        );
    end

    // ---------------- speed and drive yaw ----------------
    logic [13:0]        cruise;
    logic [15:0]        end_cap;
    logic [13:0]        vx;
    logic [QW-1:0]      qk;
    logic signed [QW:0] kk;
    logic [13:0]        vx_reg;
    logic signed [33:0] drive_prod_reg;

    always_comb
    begin
        cruise  = (max_forward_speed_reg < pursuit_speed_reg) ? max_forward_speed_reg
                                                              : pursuit_speed_reg;
        end_cap = (16'(min_speed_reg) > side_reg[40].end_dist) ? 16'(min_speed_reg)
                                                               : side_reg[40].end_dist;
        vx = cruise;
        // slow down on the last stretch, but never below the floor speed
        if (side_reg[40].is_end && end_cap < 16'(cruise))
        begin
            vx = end_cap[13:0];
        end
        qk = dv_c[QW].q;
        if (qk < QW'(curvature_deadband_reg))
        begin
            kk = '0;
        end
        else if (side_reg[40].ly[LW-1])
        begin
            kk = -$signed({1'b0, qk});
        end
        else
        begin
            kk = $signed({1'b0, qk});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vx_reg         <= vx;
            drive_prod_reg <= 34'($signed({1'b0, vx})) * 34'(kk);
        end
    end

    // ---------------- output register ----------------
    logic [12:0]        lim;
    logic signed [47:0] yaw_raw;
    logic signed [13:0] yaw_out;
    logic               turning;
    logic [13:0]        speed_out;
    logic [31:0]        out_data_reg;
    logic               out_user_reg;

    always_comb
    begin
        lim     = (max_yaw_rate_reg > YAW_CEIL) ? YAW_CEIL : max_yaw_rate_reg;
        turning = !side_reg[SIDE-1].ahead;
        yaw_raw = turning ? rsh(48'(turn_dly_reg[TDLY-1]), 9)
                          : rsh(48'(drive_prod_reg), 12);
        priority if (yaw_raw > $signed(48'(lim)))
        begin
            yaw_out = 14'(lim);
        end
        else if (yaw_raw < -$signed(48'(lim)))
        begin
            yaw_out = -$signed(14'(lim));
        end
        else
        begin
            yaw_out = 14'(yaw_raw);
        end
        // stop and spin when the target is not ahead
        speed_out = turning ? 14'd0 : vx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {4'b0, yaw_out, speed_out};
            out_user_reg <= turning;
        end
    end

    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tvalid = vld_reg[LAST];

endmodule

/* rtl/ppdc_checker.sv */
// ----------------------------------------------------------------------------
// ppdc_checker: port-level checks of the pure pursuit drive command unit
// Watches the result stream and the stall coupling between the two sides.
// ----------------------------------------------------------------------------
module ppdc_checker
    import ppdc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready
);

    // a waiting result word holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // a stalled output stops the input side
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    // turning in place never drives forward
    a_turn_stop: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[13:0] == 14'd0)
        else $error("forward speed while turning in place");

    // yaw command stays within the 1 rad/s ceiling
    a_yaw_ceil: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[27:14]) <= $signed(14'(YAW_CEIL)))
                       && ($signed(m_axis_tdata[27:14]) >= -$signed(14'(YAW_CEIL))))
        else $error("yaw command beyond ceiling");

endmodule

bind pure_pursuit_drive_command_unit ppdc_checker u_ppdc_checker (.*);
